@@ hdl/sswm_pkg.sv @@
// Shared constants, register codes, types and byte-compare functions of the wildcard matcher.
`default_nettype none

package sswm_pkg;

	localparam int unsigned MAX_PATTERN_DEF = 32;
	localparam int unsigned PAT_BYTES       = 32;
	localparam int unsigned LEN_W           = 6;
	localparam int unsigned CFG_IDX_W       = 3;
	localparam int unsigned CFG_DATA_W      = 64;
	localparam int unsigned CHAR_WORDS      = 4;

	localparam logic [7:0]       CH_ONE  = 8'h3F;
	localparam logic [LEN_W-1:0] POS_SAT = 6'd63;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHARS_LOW,
		REG_CHARS_MID_LOW,
		REG_CHARS_MID_HIGH,
		REG_CHARS_HIGH,
		REG_PATTERN_LENGTH,
		REG_STAR_PRESENT,
		REG_STAR_POSITION,
		REG_CASE_SENSITIVE
	} cfg_reg_t;

	// Pattern geometry derived from the configuration registers
	typedef struct packed {
		logic             star;
		logic [LEN_W-1:0] plen;
		logic [LEN_W-1:0] pre;
		logic [LEN_W-1:0] suf;
		logic             case_sensitive;
	} geom_t;

	// Per-byte control handed from the top level to every cell
	typedef struct packed {
		logic advance;
		logic flush;
	} cell_ctl_t;

	function automatic logic [7:0] upcase(input logic [7:0] c);
		if (c >= 8'h61 && c <= 8'h7A) begin
			return c - 8'd32;
		end
		return c;
	endfunction

	function automatic logic byte_ok(input logic [7:0] p, input logic [7:0] t,
		input logic cs);
		if (p == CH_ONE) begin
			return 1'b1;
		end
		if (cs) begin
			return p == t;
		end
		return upcase(p) == upcase(t);
	endfunction

endpackage

`default_nettype wire

@@ hdl/sswm_if.sv @@
// Channel interfaces of the wildcard matcher: text input, result output, register writes.
`default_nettype none

interface sswm_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;
	logic       empty_text;

	modport source (output valid, output text_byte, output last_byte, output empty_text,
		input ready);
	modport sink (input valid, input text_byte, input last_byte, input empty_text,
		output ready);
endinterface

interface sswm_result_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, output matched, input ready);
	modport sink (input valid, input matched, output ready);
endinterface

interface sswm_cfg_if import sswm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

@@ hdl/sswm_cfg_regs.sv @@
// Configuration registers of the wildcard matcher and the pattern geometry derived from them.
`default_nettype none

module sswm_cfg_regs import sswm_pkg::*; #(
	parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	sswm_cfg_if.sink   cfg,
	output logic [7:0] pat_bytes [PAT_BYTES],
	output geom_t      geom
);

	logic [CFG_DATA_W-1:0] chars_q [CHAR_WORDS];
	logic [LEN_W-1:0]      plen_q;
	logic                  star_q;
	logic [LEN_W-2:0]      star_pos_q;
	logic                  case_q;

	logic [LEN_W-1:0] plen_eff;
	logic [LEN_W-1:0] star_pos6;
	logic             star_eff;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < CHAR_WORDS; w++) begin
				chars_q[w] <= '0;
			end
			plen_q     <= '0;
			star_q     <= 1'b0;
			star_pos_q <= '0;
			case_q     <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.reg_index))
				REG_CHARS_LOW:      chars_q[0] <= cfg.wdata;
				REG_CHARS_MID_LOW:  chars_q[1] <= cfg.wdata;
				REG_CHARS_MID_HIGH: chars_q[2] <= cfg.wdata;
				REG_CHARS_HIGH:     chars_q[3] <= cfg.wdata;
				REG_PATTERN_LENGTH: plen_q     <= cfg.wdata[LEN_W-1:0];
				REG_STAR_PRESENT:   star_q     <= cfg.wdata[0];
				REG_STAR_POSITION:  star_pos_q <= cfg.wdata[LEN_W-2:0];
				REG_CASE_SENSITIVE: case_q     <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < PAT_BYTES; k++) begin
			pat_bytes[k] = chars_q[k / 8][(k % 8) * 8 +: 8];
		end
	end

	// Saturate the length; a star at or past the end is no star
	assign plen_eff  = (plen_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : plen_q;
	assign star_pos6 = {1'b0, star_pos_q};
	assign star_eff  = star_q && (star_pos6 < plen_eff);

	always_comb begin
		geom.star           = star_eff;
		geom.plen           = plen_eff;
		geom.pre            = star_eff ? star_pos6 : plen_eff;
		geom.suf            = star_eff ? (plen_eff - star_pos6 - LEN_W'(1)) : '0;
		geom.case_sensitive = case_q;
	end

endmodule

`default_nettype wire

@@ hdl/sswm_cell.sv @@
// One matcher cell: compares its pattern byte with the text byte and carries the suffix run flag.
`default_nettype none

module sswm_cell import sswm_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire cell_ctl_t ctl,
	input  wire [7:0]  pat_byte,
	input  wire [7:0]  text_byte,
	input  wire        case_sensitive,
	input  wire        start,
	input  wire        prev_flag,
	output logic       hit,
	output logic       flag_next,
	output logic       flag_q
);

	assign hit       = byte_ok(pat_byte, text_byte, case_sensitive);
	// Extend the neighbor's run by one byte, or open a run at the first suffix byte
	assign flag_next = hit && (start || prev_flag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctl.flush) begin
			flag_q <= 1'b0;
		end else if (ctl.advance) begin
			flag_q <= flag_next;
		end
	end

endmodule

`default_nettype wire

@@ hdl/single_star_wildcard_match.sv @@
// Top level of the single-star wildcard matcher: cell row, prefix tracking and result register.
//
//   Port     Dir    Payload                                Transfer
//   text     sink   text_byte, last_byte, empty_text       valid && ready
//   result   source matched                                valid && ready
//   cfg      sink   reg_index (3), wdata (64)              valid && ready (ready tied high)
//
// One text byte per cycle, back to back, while text.ready is high. A text's verdict is
// computed as its last byte (or an empty-text item) transfers and reaches result next cycle.
// A row of MAX_PATTERN cells, one per pattern position, compares every byte in parallel;
// run flags ride from cell to cell.
// Reset returns registers but matched_q to their reset values; no clearing pass is needed.
// A stalled result holds; text is still taken while the result register is being drained.
`default_nettype none

module single_star_wildcard_match import sswm_pkg::*; #(
	parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	sswm_text_if.sink     text,
	sswm_result_if.source result,
	sswm_cfg_if.sink      cfg
);

	localparam int unsigned IDX_W = $clog2(MAX_PATTERN);

	logic [7:0] pat_bytes [PAT_BYTES];
	geom_t      geom;

	cell_ctl_t              ctl;
	logic                   take;
	logic                   finish;
	logic [MAX_PATTERN-1:0] hit_vec;
	logic [MAX_PATTERN-1:0] flag_next_vec;
	logic [MAX_PATTERN-1:0] flag_vec;
	logic [MAX_PATTERN-1:0] end_mask;
	logic [(1<<IDX_W)-1:0]  hit_pad;

	// Text progress: byte count (saturating) and running prefix verdict
	logic [LEN_W-1:0] pos_q;
	logic             prefix_ok_q;
	logic [LEN_W-1:0] pos_next;
	logic             in_prefix;
	logic             prefix_next;
	logic             suffix_hit;
	logic             verdict;

	// Result register
	logic out_valid_q;
	logic matched_q;

	sswm_cfg_regs #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.pat_bytes(pat_bytes),
		.geom     (geom)
	);

	// Take a byte whenever the result register is free or being drained
	assign text.ready  = !out_valid_q || result.ready;
	assign take        = text.valid && text.ready;
	assign finish      = take && (text.last_byte || text.empty_text);
	assign ctl.advance = take && !text.empty_text;
	assign ctl.flush   = finish;

	// Cell k owns pattern position k. A run opens at the byte after the star and the
	// flag of the last pattern cell tells whether the newest bytes spell the suffix.
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic prev;
		if (k == 0) begin : g_first
			assign prev = 1'b0;
		end else begin : g_rest
			assign prev = flag_vec[k-1];
		end

		sswm_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctl           (ctl),
			.pat_byte      (pat_bytes[k]),
			.text_byte     (text.text_byte),
			.case_sensitive(geom.case_sensitive),
			.start         (LEN_W'(k) == geom.pre + LEN_W'(1)),
			.prev_flag     (prev),
			.hit           (hit_vec[k]),
			.flag_next     (flag_next_vec[k]),
			.flag_q        (flag_vec[k])
		);

		assign end_mask[k] = (LEN_W'(k) == geom.plen - LEN_W'(1));
	end

	always_comb begin
		hit_pad                  = '0;
		hit_pad[MAX_PATTERN-1:0] = hit_vec;
	end

	assign pos_next    = (pos_q == POS_SAT) ? pos_q : pos_q + LEN_W'(1);
	assign in_prefix   = pos_q < geom.pre;
	// The prefix compare reuses the hit of the cell at the current position
	assign prefix_next = prefix_ok_q && (!in_prefix || hit_pad[pos_q[IDX_W-1:0]]);
	assign suffix_hit  = |(flag_next_vec & end_mask);

	always_comb begin
		if (text.empty_text) begin
			verdict = geom.star ? (geom.pre == '0 && geom.suf == '0) : (geom.plen == '0);
		end else if (geom.star) begin
			verdict = prefix_next && (pos_next >= geom.pre)
				&& (geom.suf == '0 || suffix_hit);
		end else begin
			verdict = prefix_next && (pos_next == geom.plen);
		end
	end

	// Advance on each byte; drop the text state once its verdict is out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			prefix_ok_q <= 1'b1;
		end else if (ctl.flush) begin
			pos_q       <= '0;
			prefix_ok_q <= 1'b1;
		end else if (ctl.advance) begin
			pos_q       <= pos_next;
			prefix_ok_q <= prefix_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			matched_q <= verdict;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.matched = matched_q;

endmodule

`default_nettype wire

@@ bench/sswm_match_checker.sv @@
// Wildcard matcher checker: follows register writes, predicts each verdict and compares results.
module sswm_match_checker import sswm_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	sswm_text_if        text,
	sswm_result_if      result,
	sswm_cfg_if         cfg,
	output int unsigned errors,
	output int unsigned outstanding
);

	localparam int unsigned WINDOW = 31;

	// register copy
	logic [63:0]      pat_words [CHAR_WORDS];
	logic [LEN_W-1:0] pat_len;
	logic             star_on;
	logic [4:0]       star_at;
	logic             exact;

	// per-text state
	logic [LEN_W-1:0] bytes_seen;
	logic             lead_ok;
	logic [7:0]       recent [WINDOW];

	logic match_verdicts [$];

	function automatic logic [7:0] pat_char(input int unsigned i);
		int unsigned k;
		k = i & 31;
		return pat_words[k >> 3][(k & 7) * 8 +: 8];
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	function automatic logic chars_agree(input logic [7:0] p, input logic [7:0] t);
		if (p == CH_ONE) begin
			return 1'b1;
		end
		if (exact) begin
			return p == t;
		end
		return fold_case(p) == fold_case(t);
	endfunction

	function automatic void clear_text();
		bytes_seen = '0;
		lead_ok = 1'b1;
		foreach (recent[i]) begin
			recent[i] = 8'h00;
		end
	endfunction

	// Advance the per-text state by one item; queue a verdict when the text ends.
	function automatic void scan_text_item(input logic [7:0] b, input logic fin,
		input logic vacant);
		int unsigned plen, pre, suf, w;
		logic star, ok;
		plen = (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : pat_len;
		star = star_on && star_at < plen;
		pre = star ? star_at : plen;
		suf = star ? plen - star_at - 1 : 0;
		if (vacant) begin
			ok = star ? (pre == 0 && suf == 0) : (plen == 0);
			clear_text();
			match_verdicts.push_back(ok);
			return;
		end
		if (bytes_seen < pre && !chars_agree(pat_char(bytes_seen), b)) begin
			lead_ok = 1'b0;
		end
		for (int i = WINDOW - 1; i > 0; i--) begin
			recent[i] = recent[i - 1];
		end
		recent[0] = b;
		if (bytes_seen < POS_SAT) begin
			bytes_seen++;
		end
		if (!fin) begin
			return;
		end
		ok = lead_ok;
		if (!star) begin
			ok = ok && bytes_seen == plen;
		end else begin
			ok = ok && bytes_seen >= pre && bytes_seen >= suf && suf <= WINDOW;
			for (int j = 0; ok && j < suf; j++) begin
				w = suf - 1 - j;
				if (w >= WINDOW || !chars_agree(pat_char(pre + 1 + j), recent[w])) begin
					ok = 1'b0;
				end
			end
		end
		clear_text();
		match_verdicts.push_back(ok);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic expected;
		if (!arst_n) begin
			foreach (pat_words[i]) begin
				pat_words[i] = '0;
			end
			pat_len = '0;
			star_on = 1'b0;
			star_at = '0;
			exact = 1'b1;
			clear_text();
			match_verdicts.delete();
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.reg_index))
					REG_CHARS_LOW:      pat_words[0] = cfg.wdata;
					REG_CHARS_MID_LOW:  pat_words[1] = cfg.wdata;
					REG_CHARS_MID_HIGH: pat_words[2] = cfg.wdata;
					REG_CHARS_HIGH:     pat_words[3] = cfg.wdata;
					REG_PATTERN_LENGTH: pat_len = cfg.wdata[LEN_W-1:0];
					REG_STAR_PRESENT:   star_on = cfg.wdata[0];
					REG_STAR_POSITION:  star_at = cfg.wdata[4:0];
					REG_CASE_SENSITIVE: exact = cfg.wdata[0];
					default: ;
				endcase
			end
			if (text.valid && text.ready) begin
				scan_text_item(text.text_byte, text.last_byte, text.empty_text);
			end
			if (result.valid && result.ready) begin
				if (match_verdicts.size() == 0) begin
					if (errors < 10) begin
						$display("%0t: verdict with none pending, got matched=%0b",
							$time, result.matched);
					end
					errors++;
				end else begin
					expected = match_verdicts.pop_front();
					if (result.matched !== expected) begin
						if (errors < 10) begin
							$display("%0t: verdict mismatch, expected matched=%0b, got %0b",
								$time, expected, result.matched);
						end
						errors++;
					end
				end
			end
			outstanding = match_verdicts.size();
		end
	end

endmodule

@@ bench/tb_single_star_wildcard_match.sv @@
// Testbench top of the wildcard matcher: clock, reset, pattern setup, text stimulus and verdict.
module tb_single_star_wildcard_match;
	import sswm_pkg::*;

	localparam logic [7:0]  STAR_CHAR    = 8'h2A;
	localparam int unsigned RANDOM_ITEMS = 1650;
	localparam int unsigned PHASE_ITEMS  = 140;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned SETTLE       = 4;
	localparam int unsigned DRAIN_LIMIT  = 20000;

	// bytes around the letter ranges, where case folding must not reach
	localparam logic [7:0] BORDER_CHARS [4] = '{8'h40, 8'h5B, 8'h60, 8'h7B};
	localparam int unsigned GAP_CHOICES [4] = '{0, 1, 4, 16};

	logic clk;
	logic arst_n;

	sswm_text_if   text_ch ();
	sswm_result_if result_ch ();
	sswm_cfg_if    cfg_ch ();

	int unsigned mismatches;
	int unsigned pending;

	single_star_wildcard_match u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	sswm_match_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.errors      (mismatches),
		.outstanding (pending)
	);

	// Pattern as last programmed, plus the geometry the block derives from it
	logic [7:0]  pat [PAT_BYTES];
	int unsigned len_cfg;
	int unsigned star_pos_cfg;
	logic        star_cfg;
	logic        exact_cfg;
	int unsigned eff_len, eff_pre;
	logic        eff_star;

	logic [7:0]  text_buf [$];
	int unsigned burst_left;
	int unsigned gap_limit;
	int unsigned items_sent;
	logic        long_hold_go = 1'b0;
	logic        long_hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin : watchdog
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

	// Pattern byte pool: letters of both cases, wildcards, literal stars, zero and all-ones,
	// digits, the bytes that sit right next to the letter ranges and any random byte.
	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		case ($urandom_range(0, 13))
			0, 1, 2: c = 8'("a" + $urandom_range(0, 25));
			3, 4:    c = 8'("A" + $urandom_range(0, 25));
			5, 6:    c = CH_ONE;
			7:       c = STAR_CHAR;
			8:       c = 8'h00;
			9:       c = 8'hFF;
			10:      c = 8'("0" + $urandom_range(0, 9));
			11:      c = BORDER_CHARS[$urandom_range(0, 3)];
			default: c = 8'($urandom_range(0, 255));
		endcase
		return c;
	endfunction

	// Text byte that should pass against pattern byte p: anything for a wildcard,
	// sometimes the other case of a letter when folding is on, else p itself.
	function automatic logic [7:0] char_for(input logic [7:0] p);
		if (p == CH_ONE) begin
			return 8'($urandom_range(0, 255));
		end
		if (!exact_cfg && ((p >= "a" && p <= "z") || (p >= "A" && p <= "Z"))
			&& $urandom_range(0, 1) == 1) begin
			return p ^ 8'h20;
		end
		return p;
	endfunction

	function automatic logic [63:0] pack_word(input int unsigned w);
		logic [63:0] word;
		for (int b = 0; b < 8; b++) begin
			word[b*8 +: 8] = pat[w*8 + b];
		end
		return word;
	endfunction

	// Wait until every predicted verdict has come back, then let the pipe settle.
	// Sample at the falling edge so the checker's update at the rising edge is seen.
	task automatic wait_for_idle();
		int unsigned waited;
		waited = 0;
		do begin
			@(negedge clk);
			waited++;
		end while (pending != 0 && waited < DRAIN_LIMIT);
		if (pending != 0) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			repeat (SETTLE) @(posedge clk);
		end
	endtask

	// Present one register write and hold it until the transfer. Valid stays high so
	// back-to-back writes never drop and raise it in the same step.
	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata     <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	// Drain the block, then load the whole register set. Bytes past the string are random
	// so that unused pattern positions carry junk the block must ignore.
	task automatic program_pattern(input string s, input int unsigned len, input logic st,
		input int unsigned pos, input logic exact);
		for (int i = 0; i < PAT_BYTES; i++) begin
			pat[i] = (i < s.len()) ? s[i] : pick_char();
		end
		len_cfg = len;
		star_cfg = st;
		star_pos_cfg = pos;
		exact_cfg = exact;
		eff_len = (len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : len;
		eff_star = st && pos < eff_len;
		eff_pre = eff_star ? pos : eff_len;
		text_ch.valid <= 1'b0;
		wait_for_idle();
		write_reg(REG_CHARS_LOW, pack_word(0));
		write_reg(REG_CHARS_MID_LOW, pack_word(1));
		write_reg(REG_CHARS_MID_HIGH, pack_word(2));
		write_reg(REG_CHARS_HIGH, pack_word(3));
		write_reg(REG_PATTERN_LENGTH, 64'(len_cfg));
		write_reg(REG_STAR_PRESENT, 64'(star_cfg));
		write_reg(REG_STAR_POSITION, 64'(star_pos_cfg));
		write_reg(REG_CASE_SENSITIVE, 64'(exact_cfg));
		cfg_ch.valid <= 1'b0;
	endtask

	// Offer one text item. Items go out in bursts; between bursts drop valid for a
	// random gap. Return at the edge where the transfer happened.
	task automatic offer(input logic [7:0] b, input logic l, input logic e);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
			if (gap != 0) begin
				text_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		text_ch.valid      <= 1'b1;
		text_ch.text_byte  <= b;
		text_ch.last_byte  <= l;
		text_ch.empty_text <= e;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// Send the buffered text with last on its final byte; an empty buffer goes out
	// as an empty-text item.
	task automatic send_buffer();
		if (text_buf.size() == 0) begin
			offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
		end else begin
			foreach (text_buf[i]) begin
				offer(text_buf[i], i == text_buf.size() - 1, 1'b0);
			end
		end
	endtask

	task automatic send_string(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++) begin
			text_buf.push_back(s[i]);
		end
		send_buffer();
	endtask

	// Build a text that should match the current pattern: prefix, a middle of the given
	// length when a star is in effect, then the suffix. Sometimes cut the middle into the
	// suffix so prefix and suffix overlap, bend the length of a starless text, or flip
	// one bit to force a near miss.
	task automatic build_matching(input int unsigned middle);
		int unsigned cut, idx;
		text_buf.delete();
		for (int i = 0; i < eff_pre; i++) begin
			text_buf.push_back(char_for(pat[i]));
		end
		if (eff_star) begin
			repeat (middle) text_buf.push_back(8'($urandom_range(0, 255)));
			for (int i = eff_pre + 1; i < eff_len; i++) begin
				text_buf.push_back(char_for(pat[i]));
			end
			if (middle == 0 && eff_len > eff_pre + 1 && $urandom_range(0, 3) == 0) begin
				cut = $urandom_range(1, eff_len - eff_pre - 1);
				repeat (cut) text_buf.delete(eff_pre);
			end
		end else if ($urandom_range(0, 7) == 0) begin
			if ($urandom_range(0, 1) == 1 || text_buf.size() == 0) begin
				text_buf.push_back(8'($urandom_range(0, 255)));
			end else begin
				void'(text_buf.pop_back());
			end
		end
		if (text_buf.size() != 0 && $urandom_range(0, 3) == 0) begin
			idx = $urandom_range(0, text_buf.size() - 1);
			text_buf[idx] = text_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
		end
	endtask

	// Result side: keep switching between randomly chosen stall patterns. Once the
	// stimulus asks for it, hold ready low for a long stretch so the result register
	// fills and the text input backs up.
	initial begin : result_drain
		int unsigned mode, span;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(40, 200);
			for (int unsigned tick = 0; tick < span; tick++) begin
				@(posedge clk);
				if (long_hold_go && !long_hold_done) begin
					long_hold_done = 1'b1;
					result_ch.ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
				end
				case (mode)
					0:       result_ch.ready <= 1'b1;
					1:       result_ch.ready <= 1'($urandom_range(0, 1));
					2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
					default: result_ch.ready <= (tick % 4 != 3);
				endcase
			end
		end
	end

	initial begin : stimulus
		int unsigned p, len, pos, kind, phase_start, random_start;
		logic st;
		text_ch.valid      <= 1'b0;
		text_ch.text_byte  <= 8'h00;
		text_ch.last_byte  <= 1'b0;
		text_ch.empty_text <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.reg_index   <= REG_CHARS_LOW;
		cfg_ch.wdata       <= '0;
		arst_n             <= 1'b0;
		burst_left = 0;
		gap_limit = 0;
		items_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset pattern is empty: only an empty text matches.
		offer(8'hFF, 1'b1, 1'b1);
		send_string("x");

		// Plain pattern with a wildcard byte, exact compare: hit, short text, empty text.
		program_pattern("a?C", 3, 1'b0, 0, 1'b1);
		send_string("abC");
		send_string("aB");
		offer(8'h00, 1'b0, 1'b1);

		// Lone star matches everything, the empty text included.
		program_pattern("*", 1, 1'b1, 0, 1'b0);
		offer(8'h00, 1'b1, 1'b1);
		send_string("z");

		// Second star is literal; folded compare. Exact fit, overlapping prefix and
		// suffix, and a text shorter than the suffix.
		program_pattern("x*Y*", 4, 1'b1, 1, 1'b0);
		send_string("XY*");
		send_string("X*");
		send_string("x");

		// Star position past the length: no star at all. Zero and all-ones text bytes.
		program_pattern("??", 2, 1'b1, 20, 1'b1);
		text_buf = '{8'h00, 8'hFF};
		send_buffer();

		// Length beyond the maximum saturates.
		program_pattern("abcdefgh", 40, 1'b0, 0, 1'b1);
		send_string("a");

		// Random phases: a fresh register set per phase, extremes first, then mostly
		// texts built to match with random content, plus noise, cut-off, empty and long texts.
		random_start = items_sent;
		for (p = 0; items_sent - random_start < RANDOM_ITEMS; p++) begin
			case (p)
				0: begin
					len = 0;
					st = 1'b0;
					pos = 0;
				end
				1: begin
					len = 32;
					st = 1'b1;
					pos = 0;
				end
				2: begin
					len = 32;
					st = 1'b1;
					pos = 31;
				end
				3: begin
					len = $urandom_range(33, 63);
					st = 1'b1;
					pos = $urandom_range(0, 31);
				end
				default: begin
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 32)
						: $urandom_range(1, 12);
					st = ($urandom_range(0, 3) != 0);
					pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
						: $urandom_range(0, len - 1);
				end
			endcase
			program_pattern("", len, st, pos, 1'(p % 2));
			gap_limit = GAP_CHOICES[$urandom_range(0, 3)];
			if (p == 4) begin
				long_hold_go = 1'b1;
			end
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS
				&& items_sent - random_start < RANDOM_ITEMS) begin
				kind = $urandom_range(0, 99);
				if (kind < 70) begin
					build_matching(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
					send_buffer();
				end else if (kind < 78) begin
					// noise text
					text_buf.delete();
					repeat ($urandom_range(1, 40)) text_buf.push_back(8'($urandom_range(0, 255)));
					send_buffer();
				end else if (kind < 86) begin
					// drop a partial text with an empty-text item
					repeat ($urandom_range(1, 10)) offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
					offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
				end else if (kind < 93) begin
					offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
				end else begin
					// long text, often long enough to drive the byte count into saturation
					if (eff_star) begin
						build_matching($urandom_range(50, 70));
					end else begin
						text_buf.delete();
						repeat ($urandom_range(60, 75)) text_buf.push_back(8'($urandom_range(0, 255)));
					end
					send_buffer();
				end
			end
		end

		text_ch.valid <= 1'b0;
		wait_for_idle();
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/sswm_pkg.sv
hdl/sswm_if.sv
hdl/sswm_cfg_regs.sv
hdl/sswm_cell.sv
hdl/single_star_wildcard_match.sv
bench/sswm_match_checker.sv
bench/tb_single_star_wildcard_match.sv
